[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the sine test signal generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STSG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define STSG_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define STSG_ASSERT(label, clk, rst_n, prop)
`define STSG_ASSERT_IMPL(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/core/stsg_pkg.sv]
// Shared types, codes and the quarter-wave sine table function.
package stsg_pkg;

    localparam int unsigned SINE_TABLE_BITS_DEF = 10;
    localparam int unsigned SINE_W              = 15;
    localparam int unsigned ANGLE_W             = 16;
    localparam int unsigned PHASE_W             = 32;
    localparam int unsigned MIN_STEP_W          = 31;
    localparam int unsigned AMP_W               = 15;
    localparam int unsigned CFG_IDX_W           = 2;
    localparam int unsigned CFG_DATA_W          = 32;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [1:0] t_req;

    localparam t_req REQ_TICK  = 2'd0;
    localparam t_req REQ_START = 2'd1;
    localparam t_req REQ_STOP  = 2'd2;
    localparam t_req REQ_SET   = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PHASE_STEP = 2'd0;
    localparam t_cfg_idx CFG_MIN_STEP   = 2'd1;
    localparam t_cfg_idx CFG_AMPLITUDE  = 2'd2;

    localparam logic [MIN_STEP_W-1:0] MIN_STEP_RST  = 31'd4295;
    localparam logic [AMP_W-1:0]      AMPLITUDE_RST = 15'd1638;

    // sin(pi/2 * k / 2^bits) in unsigned Q0.15 from a truncated Q30 Taylor series.
    // Only evaluated on constants, so it builds a table at elaboration.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned r;
        x    = (longint'(k) * HALF_PI_Q30) >> bits;
        x2   = (x * x) >> 30;
        sum  = longint'(x);
        term = ((x * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        r = (longint'(sum) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[SINE_W-1:0];
    endfunction

endpackage

[rtl/core/stsg_sine_rom.sv]
// Quarter-wave sine lookup table with a registered read port.
module stsg_sine_rom #(
    parameter int unsigned TABLE_BITS = stsg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [TABLE_BITS:0]         i_addr,
    output logic [stsg_pkg::SINE_W-1:0] o_data
);
    import stsg_pkg::*;

    localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

    logic [SINE_W-1:0] w_tab [DEPTH];
    logic [SINE_W-1:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_tab
        assign w_tab[g] = quarter_sine(g, TABLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_tab[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

[rtl/core/sine_test_signal_generator_unit.sv]
// Top level of the sine test signal generator: phase accumulator, table and output stage.
// A tick or stop result passes the table read stage and then the output register,
// so its command transfer can follow once the output register holds it at the earliest.
// Throughput: one item per cycle while m_axis_tready is high; the table read stage and
// the output register each hold one item, so one more item is taken while a result waits.
// Reset (synchronous, active low) clears phase, held surfaces and valid flags,
// and loads phase_step 0, min_step 4295 and amplitude 1638.
module sine_test_signal_generator_unit #(
    parameter int unsigned SINE_TABLE_BITS = stsg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [stsg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stsg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Request stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // aileron_value, elevator_value
    input  logic [1:0]                      s_axis_tuser,  // req_type
    // Command stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [47:0]                     m_axis_tdata   // aileron_one, aileron_two,
                                                            // elevator_cmd
);
    import stsg_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned TB = SINE_TABLE_BITS;

    // Configuration registers.
    logic [PHASE_W-1:0]    r_phase_step;
    logic [MIN_STEP_W-1:0] r_min_step;
    logic [AMP_W-1:0]      r_amplitude;

    // Accumulator and held surfaces.
    logic [PHASE_W-1:0]    r_phase;
    logic [PHASE_W-1:0]    n_phase;
    logic [ANGLE_W-1:0]    r_held_ail;
    logic [ANGLE_W-1:0]    r_held_elev;

    // Table read stage.
    logic                  r_s1_vld;
    t_req                  r_s1_req;
    logic                  r_s1_neg;
    logic [ANGLE_W-1:0]    r_s1_ail;
    logic [ANGLE_W-1:0]    r_s1_elev;

    // Output register.
    logic                  r_out_vld;
    logic [ANGLE_W-1:0]    r_out_ail;
    logic [ANGLE_W-1:0]    r_out_elev;

    logic                  w_in_xfer;
    logic                  w_out_en;
    logic                  w_s1_en;
    t_req                  w_req;
    logic [TB-1:0]         w_k;
    logic [TB:0]           w_addr;
    logic [SINE_W-1:0]     w_rom;
    logic signed [ANGLE_W-1:0]   w_sine;
    logic signed [2*ANGLE_W-1:0] w_prod;
    logic [PHASE_W-1:0]    w_mag;
    logic                  w_drive;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_min_step   <= MIN_STEP_RST;
            r_amplitude  <= AMPLITUDE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                CFG_MIN_STEP:   r_min_step   <= i_cfg_data[MIN_STEP_W-1:0];
                CFG_AMPLITUDE:  r_amplitude  <= i_cfg_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: the output register loads when empty or drained,
    // the table stage loads when empty or moving forward.
    assign w_out_en      = !r_out_vld || m_axis_tready;
    assign w_s1_en       = !r_s1_vld || w_out_en;
    assign s_axis_tready = w_s1_en;
    assign w_in_xfer     = s_axis_tvalid && w_s1_en;
    assign w_req         = t_req'(s_axis_tuser);

    always_comb begin
        n_phase = r_phase;
        if (w_in_xfer) begin
            unique case (w_req)
                REQ_TICK:  n_phase = r_phase + r_phase_step;
                REQ_START: n_phase = '0;
                REQ_STOP:  n_phase = r_phase;
                REQ_SET:   n_phase = r_phase;
            endcase
        end
    end

    // Odd quadrants read the table mirrored.
    assign w_k    = n_phase[PHASE_W-3 -: TB];
    assign w_addr = n_phase[PHASE_W-2] ? ((TB+1)'(1 << TB) - {1'b0, w_k}) : {1'b0, w_k};

    stsg_sine_rom #(
        .TABLE_BITS (TB)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_in_xfer),
        .i_addr (w_addr),
        .o_data (w_rom)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (w_s1_en) begin
                r_s1_vld <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_req  <= w_req;
            r_s1_neg  <= n_phase[PHASE_W-1];
            r_s1_ail  <= s_axis_tdata[ANGLE_W-1:0];
            r_s1_elev <= s_axis_tdata[2*ANGLE_W-1:ANGLE_W];
        end
    end

    // Output stage: signed sine times amplitude, floor back to Q2.13.
    assign w_sine  = r_s1_neg ? -signed'({1'b0, w_rom}) : signed'({1'b0, w_rom});
    assign w_prod  = signed'({{(ANGLE_W+1){1'b0}}, r_amplitude}) *
                     signed'({{ANGLE_W{w_sine[ANGLE_W-1]}}, w_sine});
    assign w_mag   = r_phase_step[PHASE_W-1] ? (PHASE_W'(0) - r_phase_step) : r_phase_step;
    assign w_drive = w_mag > {1'b0, r_min_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_ail  <= '0;
            r_held_elev <= '0;
            r_out_vld   <= 1'b0;
        end else if (w_out_en) begin
            r_out_vld <= 1'b0;
            if (r_s1_vld) begin
                unique case (r_s1_req)
                    REQ_TICK: begin
                        r_out_vld <= 1'b1;
                        if (w_drive) begin
                            r_held_ail  <= w_prod[AMP_W+ANGLE_W-1:AMP_W];
                            r_held_elev <= '0;
                        end
                    end
                    REQ_STOP: begin
                        r_out_vld <= 1'b1;
                    end
                    REQ_SET: begin
                        r_held_ail  <= r_s1_ail;
                        r_held_elev <= r_s1_elev;
                    end
                    REQ_START: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en && r_s1_vld) begin
            if (r_s1_req == REQ_STOP) begin
                r_out_ail  <= '0;
                r_out_elev <= '0;
            end else if (w_drive) begin
                r_out_ail  <= w_prod[AMP_W+ANGLE_W-1:AMP_W];
                r_out_elev <= '0;
            end else begin
                r_out_ail  <= r_held_ail;
                r_out_elev <= r_held_elev;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_elev, r_out_ail, r_out_ail};

    `STSG_ASSERT(a_ail_pair, i_clk, i_rst_n,
        m_axis_tvalid |-> (m_axis_tdata[15:0] == m_axis_tdata[31:16]))
    `STSG_ASSERT(a_ready_full, i_clk, i_rst_n,
        !s_axis_tready |-> (r_s1_vld && r_out_vld))
    `STSG_ASSERT_IMPL(a_start_clr, i_clk, i_rst_n,
        w_in_xfer && (w_req == REQ_START), r_phase == '0)
    `STSG_ASSERT_IMPL(a_stop_zero, i_clk, i_rst_n,
        w_out_en && r_s1_vld && (r_s1_req == REQ_STOP),
        m_axis_tvalid && (m_axis_tdata == '0))

endmodule
